@@ src/ethernet_fcs_appender_top_defines.svh @@
// ----------------------------------------------------------------------------
// Ethernet FCS appender: assertion macros
// Shared assertion forms for the checker bound to the top level.
// ----------------------------------------------------------------------------
`ifndef ETHERNET_FCS_APPENDER_TOP_DEFINES_SVH
`define ETHERNET_FCS_APPENDER_TOP_DEFINES_SVH

// Clocked assertion, disabled while reset is asserted.
`define EFA_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked assertion that is also checked during reset.
`define EFA_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ src/efa_pkg.sv @@
// ----------------------------------------------------------------------------
// Ethernet FCS appender: package
// Beat types, queue entry type, CRC constants and the byte-wide CRC update.
// ----------------------------------------------------------------------------
`default_nettype none

package efa_pkg;

    localparam logic [31:0] CRC_INIT    = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_POLY    = 32'hEDB8_8320;
    localparam logic [1:0]  QUEUE_DEPTH = 2'd2;
    localparam logic [1:0]  FCS_LAST    = 2'd3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_beat_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_fcs;
        logic       frame_end;
    } out_beat_t;

    typedef struct packed {
        logic [7:0]  data;
        logic        last;
        logic [31:0] fcs;
    } q_entry_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

    // Reflected CRC-32, one byte, LSB first.
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] din);
        logic [31:0] c;
        c = crc ^ {24'd0, din};
        for (int b = 0; b < 8; b++)
        begin
            c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
        end
        return c;
    endfunction

endpackage

`default_nettype wire

@@ src/efa_front.sv @@
// ----------------------------------------------------------------------------
// Ethernet FCS appender: front end
// Accepts byte beats, runs the CRC and pushes each byte with its FCS.
// ----------------------------------------------------------------------------
`default_nettype none

module efa_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              byte_valid,
    input  wire efa_pkg::in_beat_t byte_data,
    input  wire efa_pkg::q_status_t q_status,
    output logic                   push,
    output efa_pkg::q_entry_t      push_entry
);

    logic [31:0] crc_reg;
    logic [31:0] crc_next;
    logic [31:0] crc_upd;

    assign push    = byte_valid && !q_status.full;
    assign crc_upd = efa_pkg::crc_byte(crc_reg, byte_data.data_byte);

    always_comb
    begin
        push_entry.data = byte_data.data_byte;
        push_entry.last = byte_data.last_byte;
        push_entry.fcs  = ~crc_upd;
        crc_next        = crc_reg;
        if (push)
        begin
            crc_next = byte_data.last_byte ? efa_pkg::CRC_INIT : crc_upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg <= efa_pkg::CRC_INIT;
        end
        else
        begin
            crc_reg <= crc_next;
        end
    end

endmodule

`default_nettype wire

@@ src/efa_queue.sv @@
// ----------------------------------------------------------------------------
// Ethernet FCS appender: decoupling queue
// Two-entry FIFO between front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module efa_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire efa_pkg::q_entry_t  push_entry,
    input  wire logic               pop,
    output efa_pkg::q_entry_t       head,
    output efa_pkg::q_status_t      status
);

    efa_pkg::q_entry_t entry0_reg;
    efa_pkg::q_entry_t entry1_reg;
    logic              wr_ptr_reg;
    logic              wr_ptr_next;
    logic              rd_ptr_reg;
    logic              rd_ptr_next;
    logic [1:0]        count_reg;
    logic [1:0]        count_next;
    logic              do_push;
    logic              do_pop;

    assign status.empty = (count_reg == 2'd0);
    assign status.full  = (count_reg == efa_pkg::QUEUE_DEPTH);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head         = rd_ptr_reg ? entry1_reg : entry0_reg;

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push && !wr_ptr_reg)
        begin
            entry0_reg <= push_entry;
        end
        if (do_push && wr_ptr_reg)
        begin
            entry1_reg <= push_entry;
        end
    end

endmodule

`default_nettype wire

@@ src/efa_back.sv @@
// ----------------------------------------------------------------------------
// Ethernet FCS appender: back end
// Drains the queue into the output register, expanding the last byte of a
// frame into itself plus four FCS bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module efa_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire efa_pkg::q_entry_t  head,
    input  wire efa_pkg::q_status_t q_status,
    output logic                    pop,
    output logic                    result_valid,
    input  wire logic               result_stall,
    output efa_pkg::out_beat_t      result_data
);

    typedef enum logic [1:0] {
        ST_DATA = 2'b01,
        ST_FCS  = 2'b10
    } back_state_t;

    back_state_t        state_reg;
    back_state_t        state_next;
    logic [1:0]         idx_reg;
    logic [1:0]         idx_next;
    logic [31:0]        fcs_reg;
    logic [31:0]        fcs_next;
    logic               valid_reg;
    logic               valid_next;
    efa_pkg::out_beat_t out_reg;
    efa_pkg::out_beat_t out_next;
    logic               can_load;
    logic               load;

    // output register is free when empty or being taken this cycle
    assign can_load     = !valid_reg || !result_stall;
    assign result_valid = valid_reg;
    assign result_data  = out_reg;

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        fcs_next   = fcs_reg;
        out_next   = out_reg;
        load       = 1'b0;
        pop        = 1'b0;
        unique case (state_reg)
            ST_DATA:
            begin
                if (can_load && !q_status.empty)
                begin
                    load               = 1'b1;
                    pop                = 1'b1;
                    out_next.out_byte  = head.data;
                    out_next.is_fcs    = 1'b0;
                    out_next.frame_end = 1'b0;
                    fcs_next           = head.fcs;
                    idx_next           = 2'd0;
                    if (head.last)
                    begin
                        state_next = ST_FCS;
                    end
                end
            end
            ST_FCS:
            begin
                if (can_load)
                begin
                    load               = 1'b1;
                    out_next.out_byte  = fcs_reg[7:0];
                    out_next.is_fcs    = 1'b1;
                    out_next.frame_end = (idx_reg == efa_pkg::FCS_LAST);
                    fcs_next           = {8'd0, fcs_reg[31:8]};
                    idx_next           = idx_reg + 2'd1;
                    if (idx_reg == efa_pkg::FCS_LAST)
                    begin
                        state_next = ST_DATA;
                    end
                end
            end
            default:
            begin
                state_next = ST_DATA;
            end
        endcase
        valid_next = load ? 1'b1 : (valid_reg && result_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_DATA;
            idx_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fcs_reg <= fcs_next;
        out_reg <= out_next;
    end

endmodule

`default_nettype wire

@@ src/ethernet_fcs_appender_top.sv @@
// ----------------------------------------------------------------------------
// Ethernet FCS appender: top level
// Passes a byte stream through and appends the CRC-32 frame check sequence.
// ----------------------------------------------------------------------------
// Frame bytes come in one beat each on the byte channel, last_byte set on the
// final byte of a frame. Every byte goes out unchanged; after the final byte
// the four FCS bytes follow, least significant first, is_fcs set on all four
// and frame_end on the fourth. Rate: the input takes one beat per cycle; each
// ordinary byte gives one output beat and a final byte gives five, the four
// extra set by the back-end FCS sequencer, which drives one output beat per
// cycle when not stalled. The front end stalls only when its two-entry
// queue is full. Each byte is registered in a queue entry, then in out_reg.
// ----------------------------------------------------------------------------
`default_nettype none

module ethernet_fcs_appender_top (
    input  wire logic               clk,
    input  wire logic               rst_n,
    // byte channel (frame bytes without FCS)
    input  wire logic               byte_valid,
    output logic                    byte_stall,
    input  wire efa_pkg::in_beat_t  byte_data,
    // result channel (frame bytes plus FCS)
    output logic                    result_valid,
    input  wire logic               result_stall,
    output efa_pkg::out_beat_t      result_data
);

    // front end -> queue
    logic               push;
    efa_pkg::q_entry_t  push_entry;
    // queue -> back end
    logic               pop;
    efa_pkg::q_entry_t  head;
    efa_pkg::q_status_t q_status;

    // input is held off only by a full queue
    assign byte_stall = q_status.full;

    // Front end: CRC accumulator; each beat carries the FCS as of that byte,
    // so only the final byte's FCS is ever used downstream.
    efa_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_data  (byte_data),
        .q_status   (q_status),
        .push       (push),
        .push_entry (push_entry)
    );

    // Two-entry queue decouples input acceptance from FCS insertion.
    efa_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .status     (q_status)
    );

    // Back end: output register plus FCS byte sequencer.
    efa_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .q_status     (q_status),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data)
    );

endmodule

`default_nettype wire

@@ src/efa_checker.sv @@
// ----------------------------------------------------------------------------
// Ethernet FCS appender: port checker
// Watches the top-level ports for framing and output hold rules.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ethernet_fcs_appender_top_defines.svh"

module efa_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               byte_valid,
    input wire logic               byte_stall,
    input wire efa_pkg::in_beat_t  byte_data,
    input wire logic               result_valid,
    input wire logic               result_stall,
    input wire efa_pkg::out_beat_t result_data
);

    logic out_beat;
    logic in_beat;
    logic stalled;
    logic fcs_mid;
    logic end_beat;
    logic end_bad;
    logic fcs_follow;
    logic data_follow;

    assign out_beat    = result_valid && !result_stall;
    assign in_beat     = byte_valid && !byte_stall;
    assign stalled     = result_valid && result_stall;
    assign fcs_mid     = out_beat && result_data.is_fcs && !result_data.frame_end;
    assign end_beat    = out_beat && result_data.frame_end;
    assign end_bad     = result_valid && result_data.frame_end && !result_data.is_fcs;
    assign fcs_follow  = !result_valid || result_data.is_fcs;
    assign data_follow = !result_valid || !result_data.is_fcs;

    // stalled result beat holds
    `EFA_ASSERT(a_hold, clk, rst_n, stalled |=> result_valid && $stable(result_data), "beat changed")

    // frame_end only on an FCS byte
    `EFA_ASSERT(a_end_is_fcs, clk, rst_n, !end_bad, "frame_end without is_fcs")

    // FCS bytes run back to back until frame_end
    `EFA_ASSERT(a_fcs_run, clk, rst_n, fcs_mid |=> fcs_follow, "FCS run broken")

    // after frame_end the next beat is frame data
    `EFA_ASSERT(a_after_end, clk, rst_n, end_beat |=> data_follow, "FCS byte after frame end")

    // a rising result valid always traces back to an earlier input beat
    `EFA_ASSERT(a_cause, clk, rst_n, $rose(result_valid) |-> $past(in_beat, 2), "beat without input")

endmodule

bind ethernet_fcs_appender_top efa_checker u_efa_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .byte_data    (byte_data),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_data  (result_data)
);

`default_nettype wire
